### rtl/serial_frame_deframer_macros.svh
// Assertion macros shared by the deframer modules
`ifndef SERIAL_FRAME_DEFRAMER_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies a result on the same edge
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a result on the next edge
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFD_ASSERT(lbl, prop, msg)
`define SFD_ASSERT_IMP(lbl, ante, cons, msg)
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/sfd_pkg.sv
// Types, constants and codes shared by the deframer modules
package sfd_pkg;

  // Payload buffer depth and index width
  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int MAXL_W  = 6;
  localparam int CFGI_W  = 2;
  localparam int ODATA_W = 40;
  localparam int OUSER_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFGI_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_MAX_LENGTH  = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;
  localparam logic [MAXL_W-1:0] MAX_LENGTH_RST  = 6'd32;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_SYNC1,
    S_SYNC2,
    S_TYPE,
    S_ID,
    S_LEN,
    S_PAYLOAD,
    S_CHECK,
    S_EMIT_RD,
    S_EMIT_WR
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    ld_type;
    logic    ld_id;
    logic    ld_len;
    logic    ld_payload;
    logic    ld_status;
    status_e status;
    logic    clr_idx;
    logic    inc_idx;
    logic    ld_item;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic byte_zero;
    logic payload_done;
    logic too_long;
    logic sum_ok;
    logic len_zero;
    logic emit_last;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/serial_frame_deframer.sv
// Top level of the serial frame deframer
// Takes one received byte per request, hunts for the two sync bytes, then reads type, id,
// length, payload and check byte; the check byte must equal the inverse of the 8-bit sum of
// type, id, length and payload. Header, sync and payload bytes are taken without a stall.
// The check byte is taken once the output register is free: a checksum failure, a too-long
// frame or an empty frame gives one status request with tlast set, while a good frame gives
// its N payload bytes, each read from the payload buffer through its registered read port
// in S_EMIT_RD and loaded in S_EMIT_WR once the output register is free; no byte is taken
// during that emission.
// The next frame's bytes are taken while the final result still waits on the master side.
module serial_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes: 0 sync_first, 1 sync_second, 2 max_length
  input  logic                          cfg_we_i,
  input  logic [sfd_pkg::CFGI_W-1:0]    cfg_idx_i,
  input  logic [sfd_pkg::BYTE_W-1:0]    cfg_data_i,
  // Received byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sfd_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] rx_byte
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] msg_type, [15:8] msg_id, [23:16] payload_len, [28:24] byte_index,
  // [36:29] data, [39:37] zero
  output logic [sfd_pkg::ODATA_W-1:0]   m_axis_tdata,
  output logic [sfd_pkg::OUSER_W-1:0]   m_axis_tuser,  // [1:0] status, [2] data_valid
  output logic                          m_axis_tlast   // last
);
  import sfd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### rtl/sfd_ram.sv
// Generic single-write, single-read RAM with registered read data
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sfd_ctrl.sv
// Frame parsing and payload emission state machine
`include "serial_frame_deframer_macros.svh"

module sfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sfd_pkg::dp_sts_t sts_i,
  output sfd_pkg::dp_cmd_t cmd_o
);
  import sfd_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, ready and datapath commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.status = ST_GOOD;
    case (state_q)
      S_SYNC1, S_SYNC2, S_TYPE, S_ID, S_LEN, S_PAYLOAD: in_ready_o = 1'b1;
      S_CHECK: in_ready_o = sts_i.out_free;
      default: in_ready_o = 1'b0;
    endcase
    accept = in_valid_i && in_ready_o;

    case (state_q)
      S_SYNC1: begin
        if (accept && sts_i.is_sync1) state_d = S_SYNC2;
      end
      S_SYNC2: begin
        if (accept) begin
          if (sts_i.is_sync2) state_d = S_TYPE;
          else if (!sts_i.is_sync1) state_d = S_SYNC1;
        end
      end
      S_TYPE: begin
        if (accept) begin
          cmd_o.ld_type = 1'b1;
          state_d = S_ID;
        end
      end
      S_ID: begin
        if (accept) begin
          cmd_o.ld_id = 1'b1;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          cmd_o.ld_len = 1'b1;
          state_d = sts_i.byte_zero ? S_CHECK : S_PAYLOAD;
        end
      end
      S_PAYLOAD: begin
        if (accept) begin
          cmd_o.ld_payload = 1'b1;
          if (sts_i.payload_done) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // Report a failed or empty frame at once, else stream the buffer
        if (accept) begin
          if (sts_i.too_long) begin
            cmd_o.ld_status = 1'b1;
            cmd_o.status    = ST_TOO_LONG;
            state_d = S_SYNC1;
          end else if (!sts_i.sum_ok) begin
            cmd_o.ld_status = 1'b1;
            cmd_o.status    = ST_BAD_SUM;
            state_d = S_SYNC1;
          end else if (sts_i.len_zero) begin
            cmd_o.ld_status = 1'b1;
            cmd_o.status    = ST_GOOD;
            state_d = S_SYNC1;
          end else begin
            cmd_o.clr_idx = 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.ld_item = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_SYNC1;
          end else begin
            cmd_o.inc_idx = 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_SYNC1;
    endcase
  end

  `SFD_ASSERT_IMP(a_no_rx_in_emit, (state_q == S_EMIT_RD || state_q == S_EMIT_WR),
                  !in_ready_o, "byte accepted during payload emission")
  `SFD_ASSERT_IMP(a_load_needs_slot, (cmd_o.ld_item || cmd_o.ld_status), sts_i.out_free,
                  "result loaded while output slot occupied")
  `SFD_ASSERT_NEXT(a_last_ends_frame, (cmd_o.ld_item && sts_i.emit_last),
                   state_q == S_SYNC1, "emission did not end at the last byte")

endmodule

### rtl/sfd_dp.sv
// Frame registers, checksum, payload buffer and output register
`include "serial_frame_deframer_macros.svh"

module sfd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfd_pkg::CFGI_W-1:0]        cfg_idx_i,
  input  logic [sfd_pkg::BYTE_W-1:0]        cfg_data_i,
  input  logic [sfd_pkg::BYTE_W-1:0]        rx_byte_i,
  input  sfd_pkg::dp_cmd_t                  cmd_i,
  output sfd_pkg::dp_sts_t                  sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sfd_pkg::ODATA_W-1:0]       out_data_o,
  output logic [sfd_pkg::OUSER_W-1:0]       out_user_o,
  output logic                              out_last_o
);
  import sfd_pkg::*;

  logic [BYTE_W-1:0] sync1_q, sync2_q;
  logic [MAXL_W-1:0] maxl_q;
  logic [BYTE_W-1:0] type_q, id_q, len_q, seen_q, sum_q;
  logic [IDX_W-1:0]  idx_q;
  logic [BYTE_W-1:0] limit, seen_inc, rdata;
  logic              ram_we;

  logic              ov_q;
  status_e           ost_q;
  logic [BYTE_W-1:0] otype_q, oid_q, olen_q, odata_q;
  logic [IDX_W-1:0]  oidx_q;
  logic              odv_q, olast_q;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync1_q <= SYNC_FIRST_RST;
      sync2_q <= SYNC_SECOND_RST;
      maxl_q  <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync1_q <= cfg_data_i;
        CFG_SYNC_SECOND: sync2_q <= cfg_data_i;
        CFG_MAX_LENGTH:  maxl_q  <= cfg_data_i[MAXL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective length limit, capped at the buffer depth
  assign limit = (BYTE_W'(maxl_q) > BYTE_W'(MAX_PAYLOAD)) ? BYTE_W'(MAX_PAYLOAD)
                                                          : BYTE_W'(maxl_q);
  assign seen_inc = seen_q + 8'd1;

  // Frame header, byte count and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= '0;
      id_q   <= '0;
      len_q  <= '0;
      seen_q <= '0;
      sum_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.ld_type) begin
        type_q <= rx_byte_i;
        sum_q  <= rx_byte_i;
      end
      if (cmd_i.ld_id) begin
        id_q  <= rx_byte_i;
        sum_q <= sum_q + rx_byte_i;
      end
      if (cmd_i.ld_len) begin
        len_q  <= rx_byte_i;
        seen_q <= '0;
        sum_q  <= sum_q + rx_byte_i;
      end
      if (cmd_i.ld_payload) begin
        seen_q <= seen_inc;
        sum_q  <= sum_q + rx_byte_i;
      end
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.inc_idx) idx_q <= idx_q + 1'b1;
    end
  end

  // Store payload bytes of frames that fit
  assign ram_we = cmd_i.ld_payload && !sts_o.too_long;

  sfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (seen_q[IDX_W-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Status towards the controller
  always_comb begin
    sts_o.is_sync1     = (rx_byte_i == sync1_q);
    sts_o.is_sync2     = (rx_byte_i == sync2_q);
    sts_o.byte_zero    = (rx_byte_i == '0);
    sts_o.payload_done = (seen_inc >= len_q);
    sts_o.too_long     = (len_q > limit);
    sts_o.sum_ok       = (rx_byte_i == ~sum_q);
    sts_o.len_zero     = (len_q == '0);
    sts_o.emit_last    = ((BYTE_W'(idx_q) + 8'd1) == len_q);
    sts_o.out_free     = !ov_q || out_ready_i;
  end

  // Output handshake flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.ld_status || cmd_i.ld_item) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Output payload register: hold the request until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_status || cmd_i.ld_item) begin
      otype_q <= type_q;
      oid_q   <= id_q;
      olen_q  <= len_q;
    end
    if (cmd_i.ld_status) begin
      ost_q   <= cmd_i.status;
      oidx_q  <= '0;
      odata_q <= '0;
      odv_q   <= 1'b0;
      olast_q <= 1'b1;
    end else if (cmd_i.ld_item) begin
      ost_q   <= ST_GOOD;
      oidx_q  <= idx_q;
      odata_q <= rdata;
      odv_q   <= 1'b1;
      olast_q <= sts_o.emit_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {3'b000, odata_q, oidx_q, olen_q, oid_q, otype_q};
  assign out_user_o  = {odv_q, ost_q};
  assign out_last_o  = olast_q;

  `SFD_ASSERT_IMP(a_status_is_last, (ov_q && !odv_q), olast_q,
                  "status request not marked last")
  `SFD_ASSERT_IMP(a_no_store_in_emit, (cmd_i.ld_item || cmd_i.inc_idx), !ram_we,
                  "payload buffer written during emission")
  `SFD_ASSERT_IMP(a_payload_fits, ram_we, (seen_q < BYTE_W'(MAX_PAYLOAD)),
                  "payload write beyond buffer")

endmodule

### verif/serial_frame_deframer_checker.sv
// Checker for the serial frame deframer: predicts result requests and compares them
module serial_frame_deframer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfd_pkg::CFGI_W-1:0]   cfg_idx_i,
  input  logic [sfd_pkg::BYTE_W-1:0]   cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [sfd_pkg::BYTE_W-1:0]   s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [sfd_pkg::ODATA_W-1:0]  m_tdata_i,
  input  logic [sfd_pkg::OUSER_W-1:0]  m_tuser_i,
  input  logic                         m_tlast_i,
  output int                           errors_o,
  output int                           pending_o,
  output logic                         hunting_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  // One result request as the block should present it
  typedef struct packed {
    status_e          status;
    logic [7:0]       msg_type;
    logic [7:0]       msg_id;
    logic [7:0]       payload_len;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       data;
    logic             data_valid;
    logic             last;
  } frame_item_t;

  frame_item_t       frame_items_q[$];
  frame_item_t       want;
  int                mismatches;

  // Register copies
  logic [7:0]        sync_first_r;
  logic [7:0]        sync_second_r;
  logic [MAXL_W-1:0] max_length_r;

  // Frame parser state
  state_e            phase_r;
  logic [7:0]        type_r;
  logic [7:0]        id_r;
  logic [7:0]        len_r;
  logic [7:0]        seen_r;
  logic [7:0]        sum_r;
  logic [7:0]        payload_mem [MAX_PAYLOAD];

  assign errors_o = mismatches;

  // Length limit is max_length capped at the buffer depth
  function automatic logic frame_too_long();
    int lim;
    lim = (int'(max_length_r) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(max_length_r);
    return int'(len_r) > lim;
  endfunction

  task automatic emit_item(input status_e st, input int idx, input logic [7:0] value,
                           input logic valid, input logic fin);
    frame_item_t it;
    it.status      = st;
    it.msg_type    = type_r;
    it.msg_id      = id_r;
    it.payload_len = len_r;
    it.byte_index  = IDX_W'(idx);
    it.data        = value;
    it.data_valid  = valid;
    it.last        = fin;
    frame_items_q.push_back(it);
  endtask

  // Advance the parser by one received byte and queue what it produces
  task automatic deframe_byte(input logic [7:0] b);
    case (phase_r)
      S_SYNC1: begin
        if (b == sync_first_r) phase_r = S_SYNC2;
      end
      S_SYNC2: begin
        // a repeated first sync byte keeps waiting for the second
        if (b == sync_second_r) phase_r = S_TYPE;
        else if (b != sync_first_r) phase_r = S_SYNC1;
      end
      S_TYPE: begin
        type_r  = b;
        sum_r   = b;
        phase_r = S_ID;
      end
      S_ID: begin
        id_r    = b;
        sum_r   = sum_r + b;
        phase_r = S_LEN;
      end
      S_LEN: begin
        len_r   = b;
        seen_r  = 8'd0;
        sum_r   = sum_r + b;
        phase_r = (b == 8'd0) ? S_CHECK : S_PAYLOAD;
      end
      S_PAYLOAD: begin
        // too-long frames are consumed without storing
        if (!frame_too_long() && int'(seen_r) < MAX_PAYLOAD)
          payload_mem[seen_r[IDX_W-1:0]] = b;
        sum_r  = sum_r + b;
        seen_r = seen_r + 8'd1;
        if (seen_r >= len_r) phase_r = S_CHECK;
      end
      S_CHECK: begin
        if (frame_too_long()) begin
          emit_item(ST_TOO_LONG, 0, 8'd0, 1'b0, 1'b1);
        end else if (b != ~sum_r) begin
          emit_item(ST_BAD_SUM, 0, 8'd0, 1'b0, 1'b1);
        end else if (len_r == 8'd0) begin
          emit_item(ST_GOOD, 0, 8'd0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < int'(len_r) && i < MAX_PAYLOAD; i++)
            emit_item(ST_GOOD, i, payload_mem[i], 1'b1, (i + 1 == int'(len_r)));
        end
        phase_r = S_SYNC1;
      end
      default: phase_r = S_SYNC1;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned expected,
                             input int unsigned actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  // Track registers, compare results, predict from accepted bytes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_r  = SYNC_FIRST_RST;
      sync_second_r = SYNC_SECOND_RST;
      max_length_r  = MAX_LENGTH_RST;
      phase_r       = S_SYNC1;
      type_r        = 8'd0;
      id_r          = 8'd0;
      len_r         = 8'd0;
      seen_r        = 8'd0;
      sum_r         = 8'd0;
      mismatches    = 0;
      frame_items_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_FIRST:  sync_first_r  = cfg_data_i;
          CFG_SYNC_SECOND: sync_second_r = cfg_data_i;
          CFG_MAX_LENGTH:  max_length_r  = cfg_data_i[MAXL_W-1:0];
          default: ;
        endcase
      end
      // Compare the result against the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (frame_items_q.size() == 0) begin
          $error("result request with no prediction waiting: tdata %h tuser %h",
                 m_tdata_i, m_tuser_i);
          mismatches++;
        end else begin
          want = frame_items_q.pop_front();
          check_field("status", want.status, m_tuser_i[1:0]);
          check_field("data_valid", want.data_valid, m_tuser_i[2]);
          check_field("msg_type", want.msg_type, m_tdata_i[7:0]);
          check_field("msg_id", want.msg_id, m_tdata_i[15:8]);
          check_field("payload_len", want.payload_len, m_tdata_i[23:16]);
          check_field("byte_index", want.byte_index, m_tdata_i[28:24]);
          check_field("data", want.data, m_tdata_i[36:29]);
          check_field("padding", 0, m_tdata_i[39:37]);
          check_field("last", want.last, m_tlast_i);
        end
      end
      if (s_tvalid_i && s_tready_i) deframe_byte(s_tdata_i);
    end
    pending_o <= frame_items_q.size();
    hunting_o <= (phase_r == S_SYNC1);
  end

endmodule

### verif/serial_frame_deframer_tb.sv
// Testbench top for the serial frame deframer: stimulus, idling and verdict
module serial_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  localparam logic [CFGI_W-1:0] CFG_UNUSED = 2'd3;
  localparam int                HOLD_OFF   = 16;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFGI_W-1:0]   cfg_idx = '0;
  logic [BYTE_W-1:0]   cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BYTE_W-1:0]   s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ODATA_W-1:0]  m_axis_tdata;
  logic [OUSER_W-1:0]  m_axis_tuser;
  logic                m_axis_tlast;

  int                  errors;
  int                  pending;
  logic                hunting;

  // Stimulus state
  logic [7:0]          cur_sync1 = SYNC_FIRST_RST;
  logic [7:0]          cur_sync2 = SYNC_SECOND_RST;
  logic [MAXL_W-1:0]   cur_max = MAX_LENGTH_RST;
  logic [7:0]          tx_frame[$];
  int                  frame_bytes;
  bit                  gaps_on = 1'b1;
  bit                  stalls_on = 1'b1;
  bit                  calm = 1'b0;

  serial_frame_deframer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  serial_frame_deframer_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .errors_o   (errors),
    .pending_o  (pending),
    .hunting_o  (hunting)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hold off the result stream in short random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (stalls_on && !calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one byte, with an optional gap first, and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_frame_bytes();
    foreach (tx_frame[i]) send_byte(tx_frame[i]);
    frame_bytes += tx_frame.size();
    tx_frame.delete();
  endtask

  // Append a whole frame; pattern alternates 00/FF payload bytes
  task automatic build_frame(input logic [7:0] typ, input logic [7:0] id,
                             input logic [7:0] len, input bit bad_sum, input bit pattern);
    logic [7:0] sum;
    logic [7:0] p;
    logic [7:0] chk;
    sum = typ + id + len;
    tx_frame.push_back(cur_sync1);
    tx_frame.push_back(cur_sync2);
    tx_frame.push_back(typ);
    tx_frame.push_back(id);
    tx_frame.push_back(len);
    for (int i = 0; i < int'(len); i++) begin
      p = pattern ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
      tx_frame.push_back(p);
      sum = sum + p;
    end
    chk = ~sum;
    if (bad_sum) chk = chk ^ 8'($urandom_range(1, 255));
    tx_frame.push_back(chk);
  endtask

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_SYNC_FIRST:  cur_sync1 = val;
      CFG_SYNC_SECOND: cur_sync2 = val;
      CFG_MAX_LENGTH:  cur_max   = val[MAXL_W-1:0];
      default: ;
    endcase
  endtask

  // Finish any open frame, drain all results and let the block go quiet
  task automatic settle();
    logic [7:0] filler;
    filler = 8'h00;
    while (filler == cur_sync1 || filler == cur_sync2) filler++;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (!hunting) begin
      send_byte(filler);
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  initial begin
    int kind;
    int lim;
    int r;
    int cut;
    int phase_start;
    logic [7:0] len;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers
    build_frame(8'h00, 8'h00, 8'd0, 1'b0, 1'b0);
    build_frame(8'hFF, 8'hFF, 8'd1, 1'b0, 1'b1);
    build_frame(8'h12, 8'h34, 8'd2, 1'b1, 1'b0);
    // repeated first sync byte, then a broken sync pair
    tx_frame.push_back(cur_sync1);
    build_frame(8'h5A, 8'hA5, 8'd1, 1'b0, 1'b0);
    tx_frame.push_back(cur_sync1);
    tx_frame.push_back(8'h00);
    build_frame(8'h80, 8'h01, 8'd32, 1'b0, 1'b1);
    build_frame(8'h7F, 8'hFE, 8'd33, 1'b0, 1'b0);
    send_frame_bytes();
    settle();

    // Directed: zero length limit, swapped sync extremes, unused index
    write_reg(CFG_MAX_LENGTH, 8'hC0);
    write_reg(CFG_SYNC_FIRST, 8'h00);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    write_reg(CFG_UNUSED, 8'h55);
    build_frame(8'h01, 8'h02, 8'd0, 1'b0, 1'b0);
    build_frame(8'h03, 8'h04, 8'd1, 1'b0, 1'b0);
    build_frame(8'h05, 8'h06, 8'd0, 1'b1, 1'b0);
    send_frame_bytes();
    settle();

    // Directed: limit above the buffer depth is capped, equal sync bytes
    write_reg(CFG_MAX_LENGTH, 8'h3F);
    write_reg(CFG_SYNC_FIRST, 8'hFF);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    build_frame(8'hC3, 8'h3C, 8'd32, 1'b0, 1'b0);
    build_frame(8'hC4, 8'h4C, 8'd33, 1'b0, 1'b0);
    build_frame(8'hC5, 8'h5C, 8'd48, 1'b1, 1'b0);
    send_frame_bytes();
    settle();

    // Random phases
    frame_bytes = 0;
    while (frame_bytes < 50) begin
      write_reg(CFG_SYNC_FIRST, 8'($urandom_range(0, 255)));
      write_reg(CFG_SYNC_SECOND,
                ($urandom_range(0, 7) == 0) ? cur_sync1 : 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_MAX_LENGTH, 8'($urandom_range(0, 4)));
        1:       write_reg(CFG_MAX_LENGTH, 8'($urandom_range(28, 63)));
        default: write_reg(CFG_MAX_LENGTH, 8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      lim = (int'(cur_max) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cur_max);
      phase_start = frame_bytes;
      while (frame_bytes < phase_start + 25) begin
        calm = (frame_bytes >= 30);
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          // line noise
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 12) begin
          // broken sync pair
          tx_frame.push_back(cur_sync1);
          tx_frame.push_back(8'($urandom_range(0, 255)));
          send_frame_bytes();
        end else begin
          r = $urandom_range(0, 99);
          if (r == 99) len = 8'd255;
          else if (r < 6) len = 8'd0;
          else if (r < 20) len = 8'(lim + $urandom_range(1, 4));
          else if (r < 30) len = 8'($urandom_range(0, lim));
          else len = 8'($urandom_range(0, (lim < 6) ? lim : 6));
          if ($urandom_range(0, 7) == 0) tx_frame.push_back(cur_sync1);
          build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                      ($urandom_range(0, 5) == 0), 1'b0);
          // truncate now and then, so the next frame lands mid-frame
          if (kind < 16) begin
            cut = $urandom_range(1, tx_frame.size() - 2);
            repeat (cut) void'(tx_frame.pop_back());
          end
          send_frame_bytes();
        end
      end
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/sfd_ctrl.sv
rtl/sfd_dp.sv
rtl/serial_frame_deframer.sv
verif/serial_frame_deframer_checker.sv
verif/serial_frame_deframer_tb.sv
